// ===== design/size_class_block_allocator_top_assert.svh =====
// Assertion macros shared by the allocator's checker.
// Each macro expects clk and arst_n in scope.
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define SCBA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SCBA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/scba_pkg.sv =====
`default_nettype none

package scba_pkg;

	localparam int CLASS_SLOTS     = 4;
	localparam int SIZE_W          = 21;
	localparam int COUNT_W         = 7;
	localparam int REQ_W           = 32;
	localparam int OFS_W           = 26;
	localparam int START_W         = 31;
	localparam int PROD_W          = SIZE_W + COUNT_W;
	localparam int BLK_W           = 10;
	localparam int WORD_W          = 64;
	localparam int BIT_W           = 6;
	localparam int QUOT_W          = 7;
	localparam int CFG_IDX_W       = 4;
	localparam int CFG_DATA_W      = SIZE_W;
	localparam int NUM_CLASSES_DEF = 4;
	localparam int MAX_BLOCKS_DEF  = 64;

	localparam logic [OFS_W-1:0]     OFFSET_MAX     = '1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST   = 4'd7;
	localparam logic                 CFG_FIELD_SIZE = 1'b0;
	localparam logic                 KIND_ALLOC     = 1'b0;
	localparam logic                 KIND_FREE      = 1'b1;

	localparam logic [SIZE_W-1:0]  SIZE_RESET [CLASS_SLOTS] = '{
		21'd64, 21'd256, 21'd1024, 21'd4096
	};
	localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd16;

	typedef enum logic [1:0] {
		ST_ALLOCATED = 2'd0,
		ST_NO_FIT    = 2'd1,
		ST_FREED     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} scba_status_t;

	typedef struct packed {
		logic              kind;
		logic [REQ_W-1:0]  request_bytes;
		logic [OFS_W-1:0]  release_offset;
	} scba_req_t;

	typedef struct packed {
		scba_status_t      status;
		logic [OFS_W-1:0]  block_offset;
	} scba_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LAYOUT,
		S_ALLOC_CLASS,
		S_ALLOC_RD,
		S_ALLOC_CHK,
		S_ALLOC_OFS,
		S_ALLOC_FIN,
		S_FREE_CLASS,
		S_FREE_DIV,
		S_FREE_CHK,
		S_FREE_RD,
		S_FREE_WR,
		S_RESP
	} scba_state_t;

endpackage

`default_nettype wire

// ===== design/scba_ram.sv =====
`default_nettype none

module scba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== design/size_class_block_allocator_top.sv =====
// Size-class block pool allocator.
// req channel: one item per request, kind selects allocate or free. rsp channel:
// one item per request with the status and, for an allocation, the block offset.
// cfg channel: register writes (block size and block count per class), always
// ready; write only while no request is in flight.
// Requests are handled one at a time. Each starts with a layout pass that sums
// size * count per class through one multiplier. An allocate then looks at the
// classes in turn, reads and scans 64-flag rows from the flag memory, checks the
// offset range and loads the result. A free picks its class, runs up to 7 quotient
// steps, does a read-modify-write of one flag row and loads the result.
// The next request is accepted in the cycle after the result is loaded.
// The result is held in an output register; the next request is accepted while
// it waits, and a finished request stalls in its last state until the receiver
// takes the previous result.
// Reset clears all in-use flags at once through per-row valid bits (no clearing
// pass) and loads the default class layout.
`default_nettype none

module size_class_block_allocator_top #(
	parameter int NUM_CLASSES = scba_pkg::NUM_CLASSES_DEF,
	parameter int MAX_BLOCKS  = scba_pkg::MAX_BLOCKS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             req_valid,
	output logic                                  req_ready,
	input  wire scba_pkg::scba_req_t              req,
	output logic                                  rsp_valid,
	input  wire logic                             rsp_ready,
	output scba_pkg::scba_rsp_t                   rsp,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [scba_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [scba_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import scba_pkg::*;

	localparam int LIVE   = (NUM_CLASSES < CLASS_SLOTS) ? NUM_CLASSES : CLASS_SLOTS;
	localparam int ROWS   = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int BLKX_W = BLK_W + 1;
	localparam logic [BLKX_W-1:0] MAX_BLK    = BLKX_W'(MAX_BLOCKS);
	localparam logic [BLK_W-1:0]  MAX_BLK_M1 = BLK_W'(MAX_BLOCKS - 1);
	localparam logic [1:0]        LAST_SLOT  = 2'(LIVE - 1);
	localparam logic [2:0]        LIVE_CNT   = 3'(LIVE);

	scba_state_t state_q, state_d;

	logic [SIZE_W-1:0]  size_q  [CLASS_SLOTS];
	logic [COUNT_W-1:0] count_q [CLASS_SLOTS];
	logic [START_W-1:0] start_q [CLASS_SLOTS];
	logic [BLK_W-1:0]   first_q [CLASS_SLOTS];
	logic [START_W-1:0] acc_ofs_q;
	logic [BLK_W-1:0]   acc_blk_q;
	logic [1:0]         lc_q;

	scba_req_t          req_q;
	logic [2:0]         cls_q;
	logic [ROW_W-1:0]   row_q;
	logic [BLK_W-1:0]   lo_q, hi_q, g_q;
	logic [WORD_W-1:0]  word_q;
	logic [START_W-1:0] o_q;
	logic [OFS_W-1:0]   rem_q;
	logic [QUOT_W-1:0]  q_q;
	logic [2:0]         k_q;
	scba_status_t       res_status_q;
	logic [OFS_W-1:0]   res_offset_q;
	logic [ROWS-1:0]    row_vld_q;

	logic               rsp_valid_q;
	scba_rsp_t          rsp_q;

	logic               ram_we;
	logic [ROW_W-1:0]   ram_waddr;
	logic [WORD_W-1:0]  ram_wdata;
	logic [WORD_W-1:0]  ram_rdata;
	logic               rsp_load;

	logic [1:0]         cs;
	logic               cls_done;
	logic               a_usable;
	logic [BLKX_W-1:0]  a_last;
	logic [BLK_W-1:0]   a_hi;
	logic [WORD_W-1:0]  word_now;
	logic               cand_found;
	logic [BIT_W-1:0]   cand_bit;
	logic [BLK_W-1:0]   gb;
	logic               last_row;
	logic               ofs_ok;
	logic [COUNT_W-1:0] j_ofs;
	logic [PROD_W-1:0]  prod;
	logic               f_hit;
	logic [1:0]         f_sel;
	logic [OFS_W-1:0]   f_diff;
	logic               f_too_far;
	logic [PROD_W-1:0]  dvs;
	logic               dvs_fits;
	logic [BLKX_W-1:0]  f_g;
	logic               f_match;
	logic [WORD_W-1:0]  bit_mask;

	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	scba_ram #(
		.WIDTH (WORD_W),
		.DEPTH (ROWS)
	) u_flags (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (row_q),
		.rdata (ram_rdata)
	);

	// Class checks, flag-row scan and quotient step.
	always_comb begin
		cs        = cls_q[1:0];
		cls_done  = (cls_q >= LIVE_CNT);
		a_usable  = (count_q[cs] != '0)
			&& ({{(REQ_W - SIZE_W){1'b0}}, size_q[cs]} >= req_q.request_bytes)
			&& ({1'b0, first_q[cs]} < MAX_BLK);
		a_last    = {1'b0, first_q[cs]} + BLKX_W'(count_q[cs]) - BLKX_W'(1);
		a_hi      = (a_last < MAX_BLK) ? a_last[BLK_W-1:0] : MAX_BLK_M1;

		word_now   = row_vld_q[row_q] ? ram_rdata : '0;
		cand_found = 1'b0;
		cand_bit   = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			gb = BLK_W'({row_q, BIT_W'(b)});
			if (!word_now[b] && gb >= lo_q && gb <= hi_q) begin
				cand_found = 1'b1;
				cand_bit   = BIT_W'(b);
			end
		end
		last_row = (row_q == ROW_W'(hi_q >> BIT_W));

		j_ofs  = COUNT_W'(g_q - lo_q);
		prod   = PROD_W'(j_ofs) * PROD_W'(size_q[cs]);
		ofs_ok = (o_q <= START_W'(OFFSET_MAX));

		f_hit = 1'b0;
		f_sel = '0;
		for (int c = 0; c < LIVE; c++) begin
			if (count_q[c] != '0 && start_q[c] <= START_W'(req_q.release_offset)) begin
				f_hit = 1'b1;
				f_sel = 2'(c);
			end
		end
		f_diff    = req_q.release_offset - start_q[f_sel][OFS_W-1:0];
		f_too_far = (PROD_W'(f_diff) >= {size_q[f_sel], {QUOT_W{1'b0}}});

		dvs      = PROD_W'(size_q[cs]) << k_q;
		dvs_fits = (PROD_W'(rem_q) >= dvs);

		f_g     = {1'b0, first_q[cs]} + BLKX_W'(q_q);
		f_match = (rem_q == '0) && (q_q < count_q[cs]) && (f_g < MAX_BLK);

		bit_mask = WORD_W'(1) << g_q[BIT_W-1:0];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_d = S_LAYOUT;
				end
			end
			S_LAYOUT: begin
				if (lc_q == LAST_SLOT) begin
					state_d = (req_q.kind == KIND_ALLOC) ? S_ALLOC_CLASS : S_FREE_CLASS;
				end
			end
			S_ALLOC_CLASS: begin
				if (cls_done) begin
					state_d = S_RESP;
				end else if (a_usable) begin
					state_d = S_ALLOC_RD;
				end
			end
			S_ALLOC_RD: state_d = S_ALLOC_CHK;
			S_ALLOC_CHK: begin
				if (cand_found) begin
					state_d = S_ALLOC_OFS;
				end else if (last_row) begin
					state_d = S_ALLOC_CLASS;
				end else begin
					state_d = S_ALLOC_RD;
				end
			end
			S_ALLOC_OFS: state_d = S_ALLOC_FIN;
			S_ALLOC_FIN: state_d = ofs_ok ? S_RESP : S_ALLOC_CLASS;
			S_FREE_CLASS: begin
				if (!f_hit) begin
					state_d = S_RESP;
				end else if (size_q[f_sel] == '0) begin
					state_d = S_FREE_CHK;
				end else if (f_too_far) begin
					state_d = S_RESP;
				end else begin
					state_d = S_FREE_DIV;
				end
			end
			S_FREE_DIV: begin
				if (k_q == '0) begin
					state_d = S_FREE_CHK;
				end
			end
			S_FREE_CHK: state_d = f_match ? S_FREE_RD : S_RESP;
			S_FREE_RD: state_d = S_FREE_WR;
			S_FREE_WR: state_d = S_RESP;
			S_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		req_ready = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = row_q;
		ram_wdata = word_q;
		rsp_load  = 1'b0;
		case (state_q)
			S_IDLE: req_ready = 1'b1;
			S_ALLOC_FIN: begin
				ram_we    = ofs_ok;
				ram_wdata = word_q | bit_mask;
			end
			S_FREE_WR: begin
				ram_we    = 1'b1;
				ram_wdata = word_now & ~bit_mask;
			end
			S_RESP: rsp_load = !rsp_valid_q || rsp_ready;
			default: req_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			row_vld_q   <= '0;
			rsp_valid_q <= 1'b0;
			for (int c = 0; c < CLASS_SLOTS; c++) begin
				size_q[c]  <= SIZE_RESET[c];
				count_q[c] <= COUNT_RESET;
			end
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_index <= CFG_IDX_LAST) begin
				if (cfg_index[0] == CFG_FIELD_SIZE) begin
					size_q[cfg_index[2:1]] <= cfg_data;
				end else begin
					count_q[cfg_index[2:1]] <= cfg_data[COUNT_W-1:0];
				end
			end
			if (ram_we) begin
				row_vld_q[ram_waddr] <= 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.status       <= res_status_q;
			rsp_q.block_offset <= res_offset_q;
		end
		case (state_q)
			S_IDLE: begin
				req_q        <= req;
				lc_q         <= '0;
				acc_ofs_q    <= '0;
				acc_blk_q    <= '0;
				cls_q        <= '0;
				res_offset_q <= '0;
				res_status_q <= (req.kind == KIND_ALLOC) ? ST_NO_FIT : ST_NOT_FOUND;
			end
			S_LAYOUT: begin
				start_q[lc_q] <= acc_ofs_q;
				first_q[lc_q] <= acc_blk_q;
				acc_ofs_q     <= acc_ofs_q
					+ START_W'(PROD_W'(size_q[lc_q]) * PROD_W'(count_q[lc_q]));
				acc_blk_q     <= acc_blk_q + BLK_W'(count_q[lc_q]);
				lc_q          <= lc_q + 2'd1;
			end
			S_ALLOC_CLASS: begin
				lo_q  <= first_q[cs];
				hi_q  <= a_hi;
				row_q <= ROW_W'(first_q[cs] >> BIT_W);
				if (!cls_done && !a_usable) begin
					cls_q <= cls_q + 3'd1;
				end
			end
			S_ALLOC_CHK: begin
				word_q <= word_now;
				g_q    <= BLK_W'({row_q, cand_bit});
				if (!cand_found) begin
					if (last_row) begin
						cls_q <= cls_q + 3'd1;
					end else begin
						row_q <= row_q + ROW_W'(1);
					end
				end
			end
			S_ALLOC_OFS: o_q <= start_q[cs] + START_W'(prod);
			S_ALLOC_FIN: begin
				if (ofs_ok) begin
					res_status_q <= ST_ALLOCATED;
					res_offset_q <= o_q[OFS_W-1:0];
				end else begin
					cls_q <= cls_q + 3'd1;
				end
			end
			S_FREE_CLASS: begin
				cls_q <= {1'b0, f_sel};
				rem_q <= f_diff;
				q_q   <= '0;
				k_q   <= 3'(QUOT_W - 1);
			end
			S_FREE_DIV: begin
				if (dvs_fits) begin
					rem_q    <= rem_q - dvs[OFS_W-1:0];
					q_q[k_q] <= 1'b1;
				end
				k_q <= k_q - 3'd1;
			end
			S_FREE_CHK: begin
				g_q   <= f_g[BLK_W-1:0];
				row_q <= ROW_W'(f_g[BLK_W-1:0] >> BIT_W);
			end
			S_FREE_WR: res_status_q <= ST_FREED;
			default: begin
				// hold
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/scba_checker.sv =====
`default_nettype none
`include "size_class_block_allocator_top_assert.svh"

module scba_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 req_valid,
	input wire logic                 req_ready,
	input wire logic                 rsp_valid,
	input wire logic                 rsp_ready,
	input wire scba_pkg::scba_rsp_t  rsp
);

	import scba_pkg::*;

	`SCBA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp item dropped or changed while stalled")
	`SCBA_ASSERT_NOW(a_offset_zero, rsp_valid && rsp.status != ST_ALLOCATED, rsp.block_offset == '0, "nonzero offset on a result that is not an allocation")
	`SCBA_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "second item accepted while one is in flight")
	`SCBA_ASSERT_NOW(a_rsp_from_work, $rose(rsp_valid), $past(!req_ready), "result appeared with no item in flight")

endmodule

bind size_class_block_allocator_top scba_checker u_scba_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

`default_nettype wire
